@@ hdl/rcpf_pkg.sv @@
package rcpf_pkg;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] acc_x;
      logic signed [31:0] acc_y;
      logic               saturated;
   } rsp_type;

   // Per-item sideband that rides along the whole pipeline.
   typedef struct packed {
      logic        nx;
      logic        ny;
      logic [31:0] ax;
      logic [31:0] ay;
   } side_type;

   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] root;
   } sqrt_type;

   // Two log lanes: the radius of the item and the turnover radius.
   typedef struct packed {
      logic [31:0] m_pos;
      logic [20:0] l_pos;
      logic [31:0] m_ref;
      logic [20:0] l_ref;
   } log_type;

   typedef struct packed {
      logic [31:0]       p;
      logic [15:0]       fr;
      logic signed [9:0] n;
   } exp_type;

   typedef struct packed {
      logic [60:0] rem;
      logic [63:0] den;
      logic [30:0] q;
      logic        gzero;
   } div_type;

   localparam int SQRT_STEPS = 32;
   localparam int LOG_STEPS  = 16;
   localparam int EXP_STEPS  = 16;
   localparam int DIV_STEPS  = 31;

   localparam logic [1:0] REG_RADIUS   = 2'd0;
   localparam logic [1:0] REG_SPEED    = 2'd1;
   localparam logic [1:0] REG_EXPONENT = 2'd2;

   localparam logic [30:0] RADIUS_RESET   = 31'd1048576;
   localparam logic [30:0] SPEED_RESET    = 31'd1048576;
   localparam logic [15:0] EXPONENT_RESET = 16'd6144;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] rem;
      logic [63:0] bits;
      res = 64'd0;
      rem = v;
      for (int i = 0; i < 32; i++) begin
         bits = 64'd1 << (62 - 2 * i);
         if (rem >= res + bits) begin
            rem = rem - (res + bits);
            res = (res >> 1) + bits;
         end else begin
            res = res >> 1;
         end
      end
      return res;
   endfunction

   // Coefficient 2^(2^(k-16)) in Q30, formed by repeated square roots.
   function automatic logic [30:0] exp_coef(input int unsigned k);
      logic [63:0] c;
      c = isqrt64(64'd1 << 61);
      for (int j = 15; j > int'(k); j--) begin
         c = isqrt64(c << 30);
      end
      return c[30:0];
   endfunction

   function automatic logic [4:0] msb_index(input logic [31:0] u);
      logic [4:0] e;
      e = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (u[i]) begin
            e = 5'(i);
         end
      end
      return e;
   endfunction

endpackage

@@ hdl/rcpf_sqrt_cell.sv @@
module rcpf_sqrt_cell #(
   parameter int unsigned STEP = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               up_valid,
   input  rcpf_pkg::side_type up_side,
   input  rcpf_pkg::sqrt_type up_data,
   output logic               dn_valid,
   output rcpf_pkg::side_type dn_side,
   output rcpf_pkg::sqrt_type dn_data
);

   localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

   logic               valid_ff;
   rcpf_pkg::side_type side_ff;
   rcpf_pkg::sqrt_type data_ff;
   rcpf_pkg::sqrt_type data_in;
   logic [63:0]        trial;

   always_comb begin
      trial = up_data.root + BIT;
      if (up_data.rem >= trial) begin
         data_in.rem  = up_data.rem - trial;
         data_in.root = (up_data.root >> 1) + BIT;
      end else begin
         data_in.rem  = up_data.rem;
         data_in.root = up_data.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_valid;
      end
      if (advance) begin
         side_ff <= up_side;
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_side  = side_ff;
   assign dn_data  = data_ff;

endmodule

@@ hdl/rcpf_log_cell.sv @@
module rcpf_log_cell #(
   parameter int unsigned STEP = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               up_valid,
   input  rcpf_pkg::side_type up_side,
   input  rcpf_pkg::log_type  up_data,
   output logic               dn_valid,
   output rcpf_pkg::side_type dn_side,
   output rcpf_pkg::log_type  dn_data
);

   localparam int FRAC_BIT = 15 - STEP;

   logic               valid_ff;
   rcpf_pkg::side_type side_ff;
   rcpf_pkg::log_type  data_ff;
   rcpf_pkg::log_type  data_in;
   logic [63:0]        sq_pos;
   logic [63:0]        sq_ref;

   // Squaring the Q1.31 mantissa doubles its log; a carry past 2.0 is the next bit.
   always_comb begin
      data_in = up_data;
      sq_pos  = 64'(up_data.m_pos) * 64'(up_data.m_pos);
      sq_ref  = 64'(up_data.m_ref) * 64'(up_data.m_ref);
      if (sq_pos[63]) begin
         data_in.m_pos           = sq_pos[63:32];
         data_in.l_pos[FRAC_BIT] = 1'b1;
      end else begin
         data_in.m_pos = sq_pos[62:31];
      end
      if (sq_ref[63]) begin
         data_in.m_ref           = sq_ref[63:32];
         data_in.l_ref[FRAC_BIT] = 1'b1;
      end else begin
         data_in.m_ref = sq_ref[62:31];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_valid;
      end
      if (advance) begin
         side_ff <= up_side;
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_side  = side_ff;
   assign dn_data  = data_ff;

endmodule

@@ hdl/rcpf_exp_cell.sv @@
module rcpf_exp_cell #(
   parameter int unsigned STEP = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               up_valid,
   input  rcpf_pkg::side_type up_side,
   input  rcpf_pkg::exp_type  up_data,
   output logic               dn_valid,
   output rcpf_pkg::side_type dn_side,
   output rcpf_pkg::exp_type  dn_data
);

   localparam int unsigned FR_BIT = 15 - STEP;
   localparam logic [30:0] COEF   = rcpf_pkg::exp_coef(FR_BIT);

   logic               valid_ff;
   rcpf_pkg::side_type side_ff;
   rcpf_pkg::exp_type  data_ff;
   rcpf_pkg::exp_type  data_in;
   logic [63:0]        prod;

   always_comb begin
      data_in = up_data;
      prod    = 64'(up_data.p) * 64'(COEF);
      if (up_data.fr[FR_BIT]) begin
         data_in.p = prod[61:30];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_valid;
      end
      if (advance) begin
         side_ff <= up_side;
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_side  = side_ff;
   assign dn_data  = data_ff;

endmodule

@@ hdl/rcpf_div_cell.sv @@
module rcpf_div_cell #(
   parameter int unsigned STEP = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               up_valid,
   input  rcpf_pkg::side_type up_side,
   input  rcpf_pkg::div_type  up_data,
   output logic               dn_valid,
   output rcpf_pkg::side_type dn_side,
   output rcpf_pkg::div_type  dn_data
);

   localparam int unsigned QBIT = 30 - STEP;

   logic               valid_ff;
   rcpf_pkg::side_type side_ff;
   rcpf_pkg::div_type  data_ff;
   rcpf_pkg::div_type  data_in;
   logic [63:0]        rem_top;
   logic [93:0]        den_sh;

   // Restoring division, one quotient bit per cell, most significant first.
   always_comb begin
      data_in = up_data;
      rem_top = {3'b000, up_data.rem} >> QBIT;
      den_sh  = {30'd0, up_data.den} << QBIT;
      if (rem_top >= up_data.den) begin
         data_in.rem     = up_data.rem - den_sh[60:0];
         data_in.q[QBIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_valid;
      end
      if (advance) begin
         side_ff <= up_side;
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_side  = side_ff;
   assign dn_data  = data_ff;

endmodule

@@ hdl/rotation_curve_planar_force_top.sv @@
// Channel   Direction  Beat content
// req_      in         pos_x, pos_y (signed Q12.20)
// rsp_      out        acc_x, acc_y (signed Q12.20), saturated
// csr_      in/out     APB registers: radius @0x0, speed @0x4, exponent @0x8
//
// One beat enters per cycle unless rsp_ready low freezes the pipeline; each result
// passes through the cell chains (32 sqrt, 16 log, 16 exp, 31 divide cells)
// plus nine single stages.
// Reset is synchronous; it clears all valid bits and loads register defaults.
// The whole pipeline freezes while a result waits on rsp_ready low.
module rotation_curve_planar_force_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rcpf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rcpf_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int SQ = rcpf_pkg::SQRT_STEPS;
   localparam int LG = rcpf_pkg::LOG_STEPS;
   localparam int EX = rcpf_pkg::EXP_STEPS;
   localparam int DV = rcpf_pkg::DIV_STEPS;

   logic [30:0] radius_ff;
   logic [30:0] speed_ff;
   logic [15:0] exponent_ff;

   logic advance;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff   <= rcpf_pkg::RADIUS_RESET;
         speed_ff    <= rcpf_pkg::SPEED_RESET;
         exponent_ff <= rcpf_pkg::EXPONENT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[3:2])
            rcpf_pkg::REG_RADIUS:   radius_ff   <= csr_pwdata[30:0];
            rcpf_pkg::REG_SPEED:    speed_ff    <= csr_pwdata[30:0];
            rcpf_pkg::REG_EXPONENT: exponent_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         rcpf_pkg::REG_RADIUS:   csr_prdata = {1'b0, radius_ff};
         rcpf_pkg::REG_SPEED:    csr_prdata = {1'b0, speed_ff};
         rcpf_pkg::REG_EXPONENT: csr_prdata = {16'd0, exponent_ff};
         default:                csr_prdata = 32'd0;
      endcase
   end

   logic              rsp_valid_ff;
   rcpf_pkg::rsp_type rsp_data_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Input stage: magnitudes and signs.
   logic               in_valid_ff;
   rcpf_pkg::side_type in_side_ff;
   rcpf_pkg::side_type in_side_in;

   always_comb begin
      in_side_in.nx = req_data.pos_x[31];
      in_side_in.ny = req_data.pos_y[31];
      in_side_in.ax = req_data.pos_x[31] ? (~req_data.pos_x + 32'd1) : req_data.pos_x;
      in_side_in.ay = req_data.pos_y[31] ? (~req_data.pos_y + 32'd1) : req_data.pos_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
      if (advance) begin
         in_side_ff <= in_side_in;
      end
   end

   // Squared radius, exact in 64 bits.
   logic               sq_valid_ff;
   rcpf_pkg::side_type sq_side_ff;
   logic [63:0]        r2_ff;
   logic [63:0]        r2_in;

   assign r2_in = 64'(in_side_ff.ax) * 64'(in_side_ff.ax)
                + 64'(in_side_ff.ay) * 64'(in_side_ff.ay);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else if (advance) begin
         sq_valid_ff <= in_valid_ff;
      end
      if (advance) begin
         sq_side_ff <= in_side_ff;
         r2_ff      <= r2_in;
      end
   end

   logic               sqrt_valid [0:SQ];
   rcpf_pkg::side_type sqrt_side  [0:SQ];
   rcpf_pkg::sqrt_type sqrt_data  [0:SQ];

   assign sqrt_valid[0] = sq_valid_ff;
   assign sqrt_side[0]  = sq_side_ff;
   assign sqrt_data[0]  = '{rem: r2_ff, root: 64'd0};

   for (genvar i = 0; i < SQ; i++) begin : g_sqrt
      rcpf_sqrt_cell #(.STEP(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .up_valid (sqrt_valid[i]),
         .up_side  (sqrt_side[i]),
         .up_data  (sqrt_data[i]),
         .dn_valid (sqrt_valid[i+1]),
         .dn_side  (sqrt_side[i+1]),
         .dn_data  (sqrt_data[i+1])
      );
   end

   // Log front: normalize r and r0 to Q1.31 with the exponent as integer part.
   logic               lf_valid_ff;
   rcpf_pkg::side_type lf_side_ff;
   rcpf_pkg::log_type  lf_data_ff;
   rcpf_pkg::log_type  lf_data_in;
   logic [31:0]        r_pos;
   logic [31:0]        r_ref;
   logic [4:0]         e_pos;
   logic [4:0]         e_ref;

   always_comb begin
      r_pos            = sqrt_data[SQ].root[31:0];
      r_ref            = {1'b0, radius_ff};
      e_pos            = rcpf_pkg::msb_index(r_pos);
      e_ref            = rcpf_pkg::msb_index(r_ref);
      lf_data_in.m_pos = r_pos << (5'd31 - e_pos);
      lf_data_in.m_ref = r_ref << (5'd31 - e_ref);
      lf_data_in.l_pos = {e_pos, 16'd0};
      lf_data_in.l_ref = {e_ref, 16'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lf_valid_ff <= 1'b0;
      end else if (advance) begin
         lf_valid_ff <= sqrt_valid[SQ];
      end
      if (advance) begin
         lf_side_ff <= sqrt_side[SQ];
         lf_data_ff <= lf_data_in;
      end
   end

   logic               log_valid [0:LG];
   rcpf_pkg::side_type log_side  [0:LG];
   rcpf_pkg::log_type  log_data  [0:LG];

   assign log_valid[0] = lf_valid_ff;
   assign log_side[0]  = lf_side_ff;
   assign log_data[0]  = lf_data_ff;

   for (genvar i = 0; i < LG; i++) begin : g_log
      rcpf_log_cell #(.STEP(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .up_valid (log_valid[i]),
         .up_side  (log_side[i]),
         .up_data  (log_data[i]),
         .dn_valid (log_valid[i+1]),
         .dn_side  (log_side[i+1]),
         .dn_data  (log_data[i+1])
      );
   end

   // Exponent: t = alpha * log2(r/r0), Q.28 product before the split.
   logic               pw_valid_ff;
   rcpf_pkg::side_type pw_side_ff;
   logic signed [37:0] prod_ff;
   logic signed [37:0] prod_in;
   logic signed [21:0] diff;
   logic signed [16:0] alpha_s;

   always_comb begin
      diff    = $signed({1'b0, log_data[LG].l_pos}) - $signed({1'b0, log_data[LG].l_ref});
      alpha_s = $signed({1'b0, exponent_ff});
      prod_in = 38'(alpha_s) * 38'(diff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_valid_ff <= 1'b0;
      end else if (advance) begin
         pw_valid_ff <= log_valid[LG];
      end
      if (advance) begin
         pw_side_ff <= log_side[LG];
         prod_ff    <= prod_in;
      end
   end

   logic               exp_valid [0:EX];
   rcpf_pkg::side_type exp_side  [0:EX];
   rcpf_pkg::exp_type  exp_data  [0:EX];

   assign exp_valid[0] = pw_valid_ff;
   assign exp_side[0]  = pw_side_ff;
   assign exp_data[0]  = '{p: 32'h4000_0000, fr: prod_ff[27:12], n: prod_ff[37:28]};

   for (genvar i = 0; i < EX; i++) begin : g_exp
      rcpf_exp_cell #(.STEP(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .up_valid (exp_valid[i]),
         .up_side  (exp_side[i]),
         .up_data  (exp_data[i]),
         .dn_valid (exp_valid[i+1]),
         .dn_side  (exp_side[i+1]),
         .dn_data  (exp_data[i+1])
      );
   end

   // Denominator 1 + 2^t in Q30.
   logic               den_valid_ff;
   rcpf_pkg::side_type den_side_ff;
   rcpf_pkg::div_type  den_data_ff;
   rcpf_pkg::div_type  den_data_in;
   logic signed [9:0]  n_val;
   logic [9:0]         n_neg;
   logic [63:0]        term;

   always_comb begin
      n_val = exp_data[EX].n;
      n_neg = 10'(-n_val);
      if (!n_val[9]) begin
         term = {32'd0, exp_data[EX].p} << n_val[4:0];
      end else if (n_neg < 10'd62) begin
         term = {32'd0, exp_data[EX].p} >> n_neg;
      end else begin
         term = 64'd0;
      end
      den_data_in.den   = 64'h4000_0000 + term;
      den_data_in.rem   = {speed_ff, 30'd0};
      den_data_in.q     = 31'd0;
      den_data_in.gzero = (n_val >= 10'sd32) || (radius_ff == 31'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         den_valid_ff <= 1'b0;
      end else if (advance) begin
         den_valid_ff <= exp_valid[EX];
      end
      if (advance) begin
         den_side_ff <= exp_side[EX];
         den_data_ff <= den_data_in;
      end
   end

   logic               div_valid [0:DV];
   rcpf_pkg::side_type div_side  [0:DV];
   rcpf_pkg::div_type  div_data  [0:DV];

   assign div_valid[0] = den_valid_ff;
   assign div_side[0]  = den_side_ff;
   assign div_data[0]  = den_data_ff;

   for (genvar i = 0; i < DV; i++) begin : g_div
      rcpf_div_cell #(.STEP(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .up_valid (div_valid[i]),
         .up_side  (div_side[i]),
         .up_data  (div_data[i]),
         .dn_valid (div_valid[i+1]),
         .dn_side  (div_side[i+1]),
         .dn_data  (div_data[i+1])
      );
   end

   // f = g^2, Q22.40.
   logic               f_valid_ff;
   rcpf_pkg::side_type f_side_ff;
   logic [61:0]        f_ff;
   logic [30:0]        g_val;

   assign g_val = div_data[DV].gzero ? 31'd0 : div_data[DV].q;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (advance) begin
         f_valid_ff <= div_valid[DV];
      end
      if (advance) begin
         f_side_ff <= div_side[DV];
         f_ff      <= 62'(g_val) * 62'(g_val);
      end
   end

   // f * |pos| split into low and high partial products.
   logic               lo_valid_ff;
   rcpf_pkg::side_type lo_side_ff;
   logic [63:0]        lo_x_ff;
   logic [63:0]        lo_y_ff;
   logic [29:0]        fhi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_valid_ff <= 1'b0;
      end else if (advance) begin
         lo_valid_ff <= f_valid_ff;
      end
      if (advance) begin
         lo_side_ff <= f_side_ff;
         lo_x_ff    <= 64'(f_ff[31:0]) * 64'(f_side_ff.ax);
         lo_y_ff    <= 64'(f_ff[31:0]) * 64'(f_side_ff.ay);
         fhi_ff     <= f_ff[61:32];
      end
   end

   logic               hi_valid_ff;
   rcpf_pkg::side_type hi_side_ff;
   logic [62:0]        s_x_ff;
   logic [62:0]        s_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_valid_ff <= 1'b0;
      end else if (advance) begin
         hi_valid_ff <= lo_valid_ff;
      end
      if (advance) begin
         hi_side_ff <= lo_side_ff;
         s_x_ff     <= 63'(64'(fhi_ff) * 64'(lo_side_ff.ax)) + 63'(lo_x_ff[63:32]);
         s_y_ff     <= 63'(64'(fhi_ff) * 64'(lo_side_ff.ay)) + 63'(lo_y_ff[63:32]);
      end
   end

   // Result sign is opposite to the position; the rail differs by sign.
   function automatic logic [32:0] axis_out(input logic neg, input logic [54:0] mag);
      logic [54:0] lim;
      logic        sat;
      sat = 1'b0;
      lim = mag;
      if (neg) begin
         if (mag > 55'h7FFF_FFFF) begin
            lim = 55'h7FFF_FFFF;
            sat = 1'b1;
         end
         return {sat, lim[31:0]};
      end
      if (mag > 55'h8000_0000) begin
         lim = 55'h8000_0000;
         sat = 1'b1;
      end
      return {sat, 32'd0 - lim[31:0]};
   endfunction

   logic [32:0]       out_x;
   logic [32:0]       out_y;
   rcpf_pkg::rsp_type rsp_data_in;

   always_comb begin
      out_x                 = axis_out(hi_side_ff.nx, s_x_ff[62:8]);
      out_y                 = axis_out(hi_side_ff.ny, s_y_ff[62:8]);
      rsp_data_in.acc_x     = out_x[31:0];
      rsp_data_in.acc_y     = out_y[31:0];
      rsp_data_in.saturated = out_x[32] | out_y[32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= hi_valid_ff;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_sat_on_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.saturated) |->
         (rsp_data_ff.acc_x == 32'sh7FFF_FFFF || rsp_data_ff.acc_x == 32'sh8000_0000 ||
          rsp_data_ff.acc_y == 32'sh7FFF_FFFF || rsp_data_ff.acc_y == 32'sh8000_0000))
      else $error("saturated flag without a clipped axis");

   a_origin_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && hi_valid_ff && hi_side_ff.ax == 32'd0 && hi_side_ff.ay == 32'd0) |=>
         (rsp_data_ff.acc_x == 32'sd0 && rsp_data_ff.acc_y == 32'sd0 &&
          !rsp_data_ff.saturated))
      else $error("nonzero acceleration at the origin");

   a_sign_x: assert property (@(posedge clock) disable iff (reset)
      (advance && hi_valid_ff && hi_side_ff.nx) |=> !rsp_data_ff.acc_x[31])
      else $error("acc_x not opposite to a negative position");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable({lf_valid_ff, pw_valid_ff, den_valid_ff, f_valid_ff}))
      else $error("pipeline moved while stalled");

endmodule

@@ sim/rotation_curve_planar_force_checker.sv @@
module rotation_curve_planar_force_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  rcpf_pkg::req_type    req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rcpf_pkg::rsp_type    rsp_data,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [3:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   input  logic                 csr_pready,
   output int                   fail_count,
   output int                   pending,
   output int                   checked_count,
   output int                   saturated_count
);

   localparam logic [63:0] LOW32 = 64'hFFFF_FFFF;

   logic [30:0]       radius_ff;
   logic [30:0]       speed_ff;
   logic [15:0]       exponent_ff;
   rcpf_pkg::rsp_type expected_accel[$];

   function automatic logic [63:0] root64(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      logic [63:0] rem;
      res = 0;
      rem = v;
      b = 64'd1 << 62;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
         if (rem >= res + b) begin
            rem = rem - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] log2_fix(input logic [63:0] u);
      int          e;
      logic [63:0] m;
      logic [63:0] frac;
      e = 31;
      frac = 0;
      while (e > 0 && !u[e]) e--;
      m = (u << (31 - e)) & LOW32;
      for (int k = 0; k < 16; k++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= (64'd1 << 32)) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      return (64'(e) << 16) | frac;
   endfunction

   function automatic logic [63:0] exp2_fix(input logic [15:0] fr);
      logic [63:0] p;
      logic [63:0] c;
      p = 64'd1 << 30;
      c = root64(64'd1 << 61);
      for (int k = 15; k >= 0; k--) begin
         if (fr[k]) p = (p * c) >> 30;
         c = root64(c << 30);
      end
      return p;
   endfunction

   function automatic logic [31:0] clip_axis(input bit neg, input logic [63:0] mag,
                                             inout bit sat);
      if (neg) begin
         if (mag > 64'h7FFF_FFFF) begin
            mag = 64'h7FFF_FFFF;
            sat = 1;
         end
         return mag[31:0];
      end
      if (mag > 64'h8000_0000) begin
         mag = 64'h8000_0000;
         sat = 1;
      end
      return 32'(((64'd1 << 32) - mag) & LOW32);
   endfunction

   function automatic rcpf_pkg::rsp_type predict_accel(input rcpf_pkg::req_type pos);
      rcpf_pkg::rsp_type res;
      bit                nx, ny, sat;
      logic [63:0]       ax, ay, r, g, f, p, den, tt, fr, lo, hi;
      longint            d, prod, n;
      nx = pos.pos_x[31];
      ny = pos.pos_y[31];
      ax = nx ? (64'd1 << 32) - {32'd0, pos.pos_x} : {32'd0, pos.pos_x};
      ay = ny ? (64'd1 << 32) - {32'd0, pos.pos_y} : {32'd0, pos.pos_y};
      r = root64(ax * ax + ay * ay);
      g = 0;
      sat = 0;
      res = '0;
      if (r == 0) return res;
      if (radius_ff != 0) begin
         d = longint'(log2_fix(r)) - longint'(log2_fix({33'd0, radius_ff}));
         prod = longint'({48'd0, exponent_ff}) * d;
         tt = 64'(prod + (longint'(1) << 40)) >> 12;
         n = longint'(tt >> 16) - 4096;
         fr = tt & 64'hFFFF;
         p = exp2_fix(fr[15:0]);
         if (n >= 32) den = 0;
         else if (n >= 0) den = (64'd1 << 30) + (p << n);
         else den = (64'd1 << 30) + ((-n) < 62 ? (p >> (-n)) : 64'd0);
         if (den != 0) g = ({33'd0, speed_ff} << 30) / den;
      end
      f = g * g;
      lo = (f & LOW32) * ax;
      hi = (f >> 32) * ax;
      res.acc_x = clip_axis(nx, (hi + (lo >> 32)) >> 8, sat);
      lo = (f & LOW32) * ay;
      hi = (f >> 32) * ay;
      res.acc_y = clip_axis(ny, (hi + (lo >> 32)) >> 8, sat);
      res.saturated = sat;
      return res;
   endfunction

   assign pending = expected_accel.size();

   always @(posedge clock) begin
      rcpf_pkg::rsp_type want;
      if (reset) begin
         radius_ff <= rcpf_pkg::RADIUS_RESET;
         speed_ff <= rcpf_pkg::SPEED_RESET;
         exponent_ff <= rcpf_pkg::EXPONENT_RESET;
         expected_accel.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            unique case (csr_paddr[3:2])
               rcpf_pkg::REG_RADIUS: begin
                  radius_ff <= csr_pwdata[30:0];
               end
               rcpf_pkg::REG_SPEED: begin
                  speed_ff <= csr_pwdata[30:0];
               end
               rcpf_pkg::REG_EXPONENT: begin
                  exponent_ff <= csr_pwdata[15:0];
               end
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) expected_accel.push_back(predict_accel(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_accel.size() == 0) begin
               $display("%0t: unexpected result beat %h", $time, rsp_data);
               fail_count++;
            end else begin
               want = expected_accel.pop_front();
               checked_count++;
               if (rsp_data.saturated) saturated_count++;
               if (rsp_data.acc_x !== want.acc_x) begin
                  $display("%0t: acc_x expected %h actual %h", $time, want.acc_x,
                           rsp_data.acc_x);
                  fail_count++;
               end
               if (rsp_data.acc_y !== want.acc_y) begin
                  $display("%0t: acc_y expected %h actual %h", $time, want.acc_y,
                           rsp_data.acc_y);
                  fail_count++;
               end
               if (rsp_data.saturated !== want.saturated) begin
                  $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                           rsp_data.saturated);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      fail_count = 0;
      checked_count = 0;
      saturated_count = 0;
   end

endmodule

@@ sim/rotation_curve_planar_force_top_test.sv @@
module rotation_curve_planar_force_top_test;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   rcpf_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   rcpf_pkg::rsp_type rsp_data;
   logic              csr_psel = 0;
   logic              csr_penable = 0;
   logic              csr_pwrite = 0;
   logic [3:0]        csr_paddr = 0;
   logic [31:0]       csr_pwdata = 0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;
   int                fail_count, pending, checked_count, saturated_count;
   int                idle_pct = 0;
   int                stall_pct = 0;

   localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

   rotation_curve_planar_force_top dut (.*);

   rotation_curve_planar_force_checker chk (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) rsp_ready <= ($urandom_range(0, 99) >= stall_pct);

   task automatic send_pos(input logic [31:0] x, input logic [31:0] y);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{pos_x: x, pos_y: y};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   task automatic drain;
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   function automatic logic [31:0] random_pos;
      case ($urandom_range(0, 3)) inside
         0: return $urandom;
         1, 2: return $signed($urandom) >>> $urandom_range(0, 31);
         default: return 32'($signed($urandom_range(0, 16)) - 8);
      endcase
   endfunction

   logic [30:0] radius_set[8];
   logic [30:0] speed_set[8];
   logic [15:0] exponent_set[8];

   initial begin
      radius_set   = '{31'd1 << 20, 31'd0, MAX31, 31'd1, 31'd1 << 18, 31'd3 << 19, 31'd0, 31'd0};
      speed_set    = '{31'd1 << 20, MAX31, MAX31, 31'd1 << 24, MAX31, 31'd0, 31'd0, 31'd0};
      exponent_set = '{16'd6144, 16'd6144, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1, 16'd0, 16'd0};
      radius_set[6] = 31'($urandom);
      speed_set[6] = 31'($urandom);
      exponent_set[6] = 16'($urandom);
      radius_set[7] = 31'($urandom_range(1, 1 << 24));
      speed_set[7] = 31'($urandom_range(1, 1 << 26));
      exponent_set[7] = 16'($urandom_range(1, 16384));

      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Register defaults, then the origin, the extremes and unit axes.
      send_pos(0, 0);
      send_pos(1, 0);
      send_pos(0, 1);
      send_pos(32'hFFFF_FFFF, 0);
      send_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_pos(32'h8000_0000, 32'h8000_0000);
      send_pos(32'h8000_0000, 32'h7FFF_FFFF);
      send_pos(32'h7FFF_FFFF, 32'h8000_0000);
      send_pos(32'd1 << 20, 0);
      send_pos(0, -(32'd1 << 20));
      send_pos(32'd3 << 20, 32'd4 << 20);
      send_pos(-32'd5, 32'd7);
      drain();

      // The register beyond the last index must be ignored.
      csr_write(2'd3, $urandom);

      for (int ph = 0; ph < 8; ph++) begin
         csr_write(rcpf_pkg::REG_RADIUS, {1'($urandom), radius_set[ph]});
         csr_write(rcpf_pkg::REG_SPEED, {1'($urandom), speed_set[ph]});
         csr_write(rcpf_pkg::REG_EXPONENT, {16'($urandom), exponent_set[ph]});
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 71; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 71; end
            default: begin idle_pct = 30; stall_pct = 30; end
         endcase
         send_pos(32'h8000_0000, 32'h8000_0000);
         send_pos(1, 32'hFFFF_FFFF);
         for (int i = 0; i < 115; i++) send_pos(random_pos(), random_pos());
         drain();
      end

      $display("Checked %0d results over 9 register settings and 4 idle mixes, %0d saturated.",
               checked_count, saturated_count);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #(8 * 2000000);
      $display("Test completed with failures");
      $finish;
   end

endmodule
